/* rtl/core/video_line_bit_cell_encoder_top_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef VIDEO_LINE_BIT_CELL_ENCODER_TOP_ASSERT_SVH
`define VIDEO_LINE_BIT_CELL_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define VLBCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vlbce: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define VLBCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vlbce: next-cycle check failed");

`endif

/* rtl/core/vlbce_pkg.sv */
package vlbce_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h45;
    localparam logic [8:0] NTSC_LINES  = 9'd253;
    localparam logic [8:0] PAL_LINES   = 9'd305;
    localparam logic [3:0] BYTES_LOW   = 4'd4;
    localparam logic [3:0] BYTES_HIGH  = 4'd10;
    localparam logic [3:0] PIX_LOW     = 4'd8;
    localparam logic [3:0] PIX_HIGH    = 4'd4;

    localparam int QUEUE_DEPTH = 2;

    // register index, taken from paddr[2]
    localparam logic REG_VIDEO_MODE  = 1'b0;
    localparam logic REG_BIT_DENSITY = 1'b1;

    // one classified byte, handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic       line_end;
        logic       field_end;
        logic       density;
    } t_desc;

endpackage

/* rtl/core/video_line_bit_cell_encoder_top.sv */
// Video line bit cell encoder. Each accepted payload byte becomes 8 bit
// cells, or 16 when it opens a line and the 0x45 header byte goes out first;
// bits leave MSB first, one cell per clock unless pop stalls, each cell
// carrying its level and width (8 pixels low density, 4 high). The front
// stage classifies a byte at push time (header, line end, field end) and
// updates the line and field counters; the back stage serializes from a
// QUEUE_DEPTH-entry queue into a one-deep output register, one byte at a
// time by the single serializer; push is taken every cycle until the queue fills.
// No clearing pass after reset. Registers: 0x0 video_mode (0 NTSC 253/254
// lines, 1 PAL 305), 0x4 bit_density (0 low, 1 high); write only while idle.
module video_line_bit_cell_encoder_top #(
    parameter int QUEUE_DEPTH = vlbce_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        o_bit_level,
    output logic [3:0]  o_cell_pixels,
    output logic        o_is_header,
    output logic        o_line_end,
    output logic        o_field_end,
    output logic        o_last,
    // APB-style config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vlbce_pkg::*;

    logic  r_video_mode;
    logic  r_bit_density;
    logic  cfg_wr;

    logic  wr, q_full, q_vld, q_rd;
    t_desc wr_desc, head;

    // config: write completes on the access phase; pready tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_mode  <= 1'b0;
            r_bit_density <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_VIDEO_MODE:  r_video_mode  <= pwdata[0];
                REG_BIT_DENSITY: r_bit_density <= pwdata[0];
                default:         r_video_mode  <= r_video_mode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_VIDEO_MODE:  prdata = {31'd0, r_video_mode};
            REG_BIT_DENSITY: prdata = {31'd0, r_bit_density};
            default:         prdata = 32'd0;
        endcase
    end

    assign full = q_full;

    // front: classify each transaction and advance line/field counters
    vlbce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (q_full),
        .i_data_byte   (i_data_byte),
        .i_video_mode  (r_video_mode),
        .i_bit_density (r_bit_density),
        .o_wr          (wr),
        .o_desc        (wr_desc)
    );

    // decoupling queue between the two stages
    vlbce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_desc  (wr_desc),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_desc  (head)
    );

    // back: one cell per cycle into the output register unless the receiver stalls
    vlbce_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_vld    (q_vld),
        .i_head        (head),
        .o_head_rd     (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_bit_level   (o_bit_level),
        .o_cell_pixels (o_cell_pixels),
        .o_is_header   (o_is_header),
        .o_line_end    (o_line_end),
        .o_field_end   (o_field_end),
        .o_last        (o_last)
    );

endmodule

/* rtl/core/vlbce_front.sv */
module vlbce_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic           i_full,
    input  logic [7:0]     i_data_byte,
    input  logic           i_video_mode,
    input  logic           i_bit_density,
    output logic           o_wr,
    output vlbce_pkg::t_desc o_desc
);
    import vlbce_pkg::*;

    logic [3:0] r_byte_pos, n_byte_pos;
    logic [8:0] r_line_pos, n_line_pos;
    logic       r_field_odd, n_field_odd;

    logic [3:0] bp1, line_bytes;
    logic [8:0] lp1, field_lines;
    logic       lend, fend;

    assign o_wr = i_push && !i_full;

    always_comb begin
        line_bytes  = i_bit_density ? BYTES_HIGH : BYTES_LOW;
        field_lines = i_video_mode ? PAL_LINES : (NTSC_LINES + {8'd0, r_field_odd});
        bp1  = r_byte_pos + 4'd1;
        lp1  = r_line_pos + 9'd1;
        lend = (bp1 >= line_bytes) || (bp1 == 4'd0);
        fend = lend && ((lp1 >= field_lines) || (lp1 == 9'd0));

        o_desc.data      = i_data_byte;
        o_desc.hdr       = (r_byte_pos == 4'd0);
        o_desc.line_end  = lend;
        o_desc.field_end = fend;
        o_desc.density   = i_bit_density;

        n_byte_pos  = r_byte_pos;
        n_line_pos  = r_line_pos;
        n_field_odd = r_field_odd;
        if (o_wr) begin
            n_byte_pos = lend ? 4'd0 : bp1;
            if (lend) begin
                n_line_pos = fend ? 9'd0 : lp1;
            end
            if (fend) begin
                n_field_odd = !r_field_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= 4'd0;
            r_line_pos  <= 9'd0;
            r_field_odd <= 1'b1;
        end else begin
            r_byte_pos  <= n_byte_pos;
            r_line_pos  <= n_line_pos;
            r_field_odd <= n_field_odd;
        end
    end

endmodule

/* rtl/core/vlbce_queue.sv */
module vlbce_queue #(
    parameter int DEPTH = vlbce_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  vlbce_pkg::t_desc i_desc,
    input  logic             i_rd,
    output logic             o_full,
    output logic             o_vld,
    output vlbce_pkg::t_desc o_desc
);
    import vlbce_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_full = (r_cnt == FULL_CNT);
    assign o_vld  = (r_cnt != '0);
    assign o_desc = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* rtl/core/vlbce_back.sv */
module vlbce_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_vld,
    input  vlbce_pkg::t_desc i_head,
    output logic             o_head_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_bit_level,
    output logic [3:0]       o_cell_pixels,
    output logic             o_is_header,
    output logic             o_line_end,
    output logic             o_field_end,
    output logic             o_last
);
    import vlbce_pkg::*;

    logic [3:0] r_cnt;
    logic       r_ovld;
    logic [3:0] idx;
    logic [2:0] bsel;
    logic       step, fin, bit_val;

    // idx 0..7 header cells, 8..15 data cells; no header skips to 8
    always_comb begin
        idx     = (!i_head.hdr && !r_cnt[3]) ? {1'b1, r_cnt[2:0]} : r_cnt;
        bsel    = ~idx[2:0];
        fin     = (idx == 4'hF);
        step    = i_head_vld && (!r_ovld || i_pop);
        bit_val = idx[3] ? i_head.data[bsel] : HEADER_BYTE[bsel];
    end

    assign o_head_rd = step && fin;
    assign o_empty   = !r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 4'd0;
            r_ovld <= 1'b0;
        end else begin
            if (step) begin
                r_cnt  <= fin ? 4'd0 : r_cnt + 4'd1;
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            o_bit_level   <= bit_val;
            o_cell_pixels <= i_head.density ? PIX_HIGH : PIX_LOW;
            o_is_header   <= !idx[3];
            o_line_end    <= fin && i_head.line_end;
            o_field_end   <= fin && i_head.field_end;
            o_last        <= fin;
        end
    end

endmodule

/* rtl/core/vlbce_checker.sv */
`include "video_line_bit_cell_encoder_top_assert.svh"

module vlbce_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_bit_level,
    input logic [3:0] o_cell_pixels,
    input logic       o_is_header,
    input logic       o_line_end,
    input logic       o_field_end,
    input logic       o_last
);

    logic       w_stall;
    logic       w_pix_ok;
    logic [8:0] w_cell;

    assign w_stall  = !empty && !pop;
    assign w_pix_ok = (o_cell_pixels == 4'd4) || (o_cell_pixels == 4'd8);
    assign w_cell   = {o_bit_level, o_cell_pixels, o_is_header, o_line_end, o_field_end, o_last};

    // a field ends only on a line end, which ends a transaction
    `VLBCE_ASSERT_NOW(a_field_in_line, i_clk, i_rst_n, !empty && o_field_end, o_line_end && o_last)
    `VLBCE_ASSERT_NOW(a_line_on_last, i_clk, i_rst_n, !empty && o_line_end, o_last)
    // header cells never close a transaction; widths are 4 or 8
    `VLBCE_ASSERT_NOW(a_hdr_not_last, i_clk, i_rst_n, !empty, !(o_is_header && o_last))
    `VLBCE_ASSERT_NOW(a_pix_legal, i_clk, i_rst_n, !empty, w_pix_ok)
    // a stalled cell holds
    `VLBCE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall, !empty && $stable(w_cell))

endmodule

bind video_line_bit_cell_encoder_top vlbce_checker u_vlbce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_bit_level   (o_bit_level),
    .o_cell_pixels (o_cell_pixels),
    .o_is_header   (o_is_header),
    .o_line_end    (o_line_end),
    .o_field_end   (o_field_end),
    .o_last        (o_last)
);

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import vlbce_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;  // cycles with work pending but no transaction
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 32;    // settle time before the verdict

    localparam logic [2:0] ADDR_VIDEO_MODE  = {REG_VIDEO_MODE, 2'b00};
    localparam logic [2:0] ADDR_BIT_DENSITY = {REG_BIT_DENSITY, 2'b00};

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

    // one bit cell as it leaves the block
    typedef struct packed {
        logic       level;
        logic [3:0] pixels;
        logic       hdr;
        logic       line_end;
        logic       field_end;
        logic       last;
    } cell_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte   = 8'h00;
    logic        empty;
    logic        pop           = 1'b0;
    logic        o_bit_level;
    logic [3:0]  o_cell_pixels;
    logic        o_is_header;
    logic        o_line_end;
    logic        o_field_end;
    logic        o_last;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // stimulus and expectations
    logic [7:0]  tx_bytes[$];
    cell_t       want_cells[$];
    int          n_queued      = 0;
    int          n_taken       = 0;
    int          n_cells       = 0;
    int          err_cnt       = 0;
    int          quiet_cycles  = 0;
    bit          in_taken      = 1'b0;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    int          hold_req      = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;

    // predictor copy of registers and line/field position
    logic        cfg_pal       = 1'b0;
    logic        cfg_high      = 1'b0;
    logic [3:0]  lb_pos        = 4'd0;
    logic [8:0]  ln_pos        = 9'd0;
    logic        fld_odd       = 1'b1;

    video_line_bit_cell_encoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .empty         (empty),
        .pop           (pop),
        .o_bit_level   (o_bit_level),
        .o_cell_pixels (o_cell_pixels),
        .o_is_header   (o_is_header),
        .o_line_end    (o_line_end),
        .o_field_end   (o_field_end),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic cell_t mk_cell(input logic lvl, input logic [3:0] px, input logic hdr);
        cell_t c;
        c        = '0;
        c.level  = lvl;
        c.pixels = px;
        c.hdr    = hdr;
        return c;
    endfunction

    // NTSC odd fields carry one extra line
    function automatic logic [8:0] field_lines_now();
        return cfg_pal ? PAL_LINES : NTSC_LINES + {8'd0, fld_odd};
    endfunction

    // One payload byte: optional header byte, then 8 data cells MSB first.
    // Line/field end flags land on the final cell of the byte.
    task automatic encode_byte(input logic [7:0] data);
        cell_t      c;
        logic [3:0] px;
        logic [3:0] per_line;
        int         i;
        px       = cfg_high ? PIX_HIGH : PIX_LOW;
        per_line = cfg_high ? BYTES_HIGH : BYTES_LOW;
        if (lb_pos == 4'd0) begin
            for (i = 7; i >= 0; i--)
                want_cells.push_back(mk_cell(HEADER_BYTE[i], px, 1'b1));
        end
        for (i = 7; i >= 1; i--)
            want_cells.push_back(mk_cell(data[i], px, 1'b0));
        c      = mk_cell(data[0], px, 1'b0);
        c.last = 1'b1;
        lb_pos = lb_pos + 4'd1;
        // a density change mid-line ends the line once the count reaches or passes
        if (lb_pos >= per_line || lb_pos == 4'd0) begin
            lb_pos     = 4'd0;
            c.line_end = 1'b1;
            ln_pos     = ln_pos + 9'd1;
            // same rule for a mode change mid-field
            if (ln_pos >= field_lines_now() || ln_pos == 9'd0) begin
                ln_pos      = 9'd0;
                c.field_end = 1'b1;
                fld_odd     = ~fld_odd;
            end
        end
        want_cells.push_back(c);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h (cell %0d)", what, got, want, n_cells);
        err_cnt++;
    endtask

    //------------------------------------------------------------------
    // Monitor: input transactions feed the predictor, result transactions
    // are checked against the oldest expected cell, register traffic
    // updates the mirror or is checked on read.
    //------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        cell_t       c;
        logic        busy;
        logic        moved;
        logic [31:0] reg_val;
        if (!i_rst_n) begin
            in_taken     = 1'b0;
            quiet_cycles = 0;
        end else begin
            busy     = (n_taken != n_queued) || (want_cells.size() != 0);
            in_taken = push && !full;
            moved    = in_taken || (pop && !empty);

            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_VIDEO_MODE)
                        cfg_pal = pwdata[0];
                    else
                        cfg_high = pwdata[0];
                end else begin
                    reg_val = {31'd0, (paddr[2] == REG_VIDEO_MODE) ? cfg_pal : cfg_high};
                    if (prdata !== reg_val)
                        report_mismatch("prdata", prdata, reg_val);
                end
            end

            if (in_taken) begin
                encode_byte(i_data_byte);
                n_taken++;
            end

            if (pop && !empty) begin
                if (want_cells.size() == 0) begin
                    report_mismatch("unexpected cell", {31'd0, o_bit_level}, 32'd0);
                end else begin
                    c = want_cells.pop_front();
                    if (o_bit_level !== c.level)
                        report_mismatch("bit_level", 32'(o_bit_level), 32'(c.level));
                    if (o_cell_pixels !== c.pixels)
                        report_mismatch("cell_pixels", 32'(o_cell_pixels), 32'(c.pixels));
                    if (o_is_header !== c.hdr)
                        report_mismatch("is_header", 32'(o_is_header), 32'(c.hdr));
                    if (o_line_end !== c.line_end)
                        report_mismatch("line_end", 32'(o_line_end), 32'(c.line_end));
                    if (o_field_end !== c.field_end)
                        report_mismatch("field_end", 32'(o_field_end), 32'(c.field_end));
                    if (o_last !== c.last)
                        report_mismatch("last", 32'(o_last), 32'(c.last));
                end
                n_cells++;
            end

            quiet_cycles = (busy && !moved) ? quiet_cycles + 1 : 0;
        end
    end

    //------------------------------------------------------------------
    // Driver: hold a byte until it is taken, then maybe idle.
    //------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || in_taken) begin
            if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                push        <= 1'b1;
                i_data_byte <= tx_bytes.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Watchdog
    always @(negedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sequencing helpers
    //------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_taken != n_queued || want_cells.size() != 0)
            @(negedge i_clk);
        #1;
    endtask

    // setup cycle, then access cycle until pready
    task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        #1;
    endtask

    // upper bits are junk on purpose: only bit 0 counts
    task automatic cfg_set(input logic pal, input logic high);
        reg_access(1'b1, ADDR_VIDEO_MODE, ($urandom & 32'hFFFF_FFFE) | {31'd0, pal});
        reg_access(1'b1, ADDR_BIT_DENSITY, ($urandom & 32'hFFFF_FFFE) | {31'd0, high});
        reg_access(1'b0, ADDR_VIDEO_MODE, 32'd0);
        reg_access(1'b0, ADDR_BIT_DENSITY, 32'd0);
    endtask

    task automatic set_idle(input idle_e idle);
        case (idle)
            IDLE_NONE: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 72; pop_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  pop_stall_pct = 72; end
            default:   begin send_idle_pct = 27; pop_stall_pct = 27; end
        endcase
    endtask

    task automatic run_phase(input int n_items, input idle_e idle, input bit hold_off,
                             input bit mid_pause);
        int k;
        set_idle(idle);
        if (hold_off)
            hold_req++;
        for (k = 0; k < n_items; k++) begin
            // sender stops until every cell so far is out
            if (mid_pause && k == n_items / 2)
                wait_drained();
            case ($urandom_range(9))
                0:       queue_byte(8'h00);
                1:       queue_byte(8'hFF);
                2:       queue_byte(HEADER_BYTE);
                default: queue_byte(8'($urandom_range(255)));
            endcase
        end
        wait_drained();
    endtask

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        cfg_set(1'b0, 1'b0);

        // directed: corner bytes at low density, header value as payload
        set_idle(IDLE_NONE);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h80);
        queue_byte(8'h01);
        queue_byte(HEADER_BYTE);
        queue_byte(8'h7F);
        wait_drained();

        // switch to high density mid-line, finish a 10-byte line
        cfg_set(1'b0, 1'b1);
        queue_byte(8'hAA);
        queue_byte(8'h55);
        queue_byte(8'hFE);
        queue_byte(8'h01);
        queue_byte(8'hF0);
        queue_byte(8'h0F);
        queue_byte(8'hC3);
        queue_byte(8'h3C);
        // leave the line at byte 5, past the low-density length
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h81);
        queue_byte(8'h7E);
        queue_byte(8'h18);
        wait_drained();

        // back to low density mid-line: next byte must close the line
        cfg_set(1'b0, 1'b0);
        queue_byte(8'hE7);
        wait_drained();

        // random part across register settings and idle patterns
        cfg_set(1'b0, 1'b1);
        run_phase(60, IDLE_SEND, 1'b0, 1'b0);
        cfg_set(1'b1, 1'b0);
        run_phase(60, IDLE_RECV, 1'b1, 1'b0);
        cfg_set(1'b1, 1'b1);
        run_phase(60, IDLE_BOTH, 1'b0, 1'b1);
        cfg_set(1'b0, 1'b0);
        run_phase(60, IDLE_NONE, 1'b0, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && want_cells.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
